/* rtl/ss_pkg.sv */
package ss_pkg;

  localparam int PATTERN_MAX_DEF   = 16;
  localparam int POSITION_BITS_DEF = 16;
  localparam int POS_OUT_BITS      = 16;
  localparam int LEN_BITS          = 5;
  localparam int CFG_INDEX_BITS    = 2;
  localparam int CFG_DATA_BITS     = 64;
  localparam int PAT_INDEX_BITS    = 7;
  localparam int QUEUE_DEPTH       = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PATTERN_LOW,
    REG_PATTERN_HIGH,
    REG_PATTERN_LENGTH,
    REG_START_POSITION
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } text_item_t;

  typedef struct packed {
    logic                    found;
    logic [POS_OUT_BITS-1:0] match_position;
    logic                    overflow;
  } result_t;

  // One classified text byte, handed from the front to the back.
  typedef struct packed {
    logic                    hit;
    logic                    last;
    logic                    empty_pattern;
    logic                    empty_hit;
    logic                    overflow;
    logic [POS_OUT_BITS-1:0] position;
  } step_rec_t;

  function automatic logic [7:0] pattern_byte(input logic [63:0] lo,
                                              input logic [63:0] hi,
                                              input logic [PAT_INDEX_BITS-1:0] k);
    logic [7:0] b;
    b = 8'd0;
    if (k < PAT_INDEX_BITS'(8)) begin
      b = lo[{k[2:0], 3'b000} +: 8];
    end else if (k < PAT_INDEX_BITS'(16)) begin
      b = hi[{k[2:0], 3'b000} +: 8];
    end
    return b;
  endfunction

endpackage

/* rtl/ss_fifo.sv */
module ss_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (AW+1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

endmodule

/* rtl/ss_front.sv */
module ss_front import ss_pkg::*; #(
  parameter int PATTERN_MAX   = PATTERN_MAX_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      accept,
  input  text_item_t                in_item,
  output step_rec_t                 rec
);

  localparam int NW   = $clog2(PATTERN_MAX + 1);
  localparam int CW   = POSITION_BITS + 1;
  localparam int LW   = (NW > LEN_BITS) ? NW : LEN_BITS;
  localparam int EW0  = (CW > POS_OUT_BITS) ? CW : POS_OUT_BITS;
  localparam int EW   = (EW0 > NW) ? EW0 : NW;

  localparam logic [CW-1:0] MAX_POS = {1'b0, {POSITION_BITS{1'b1}}};

  logic [63:0]             pattern_low;
  logic [63:0]             pattern_high;
  logic [LEN_BITS-1:0]     pattern_length;
  logic [POS_OUT_BITS-1:0] start_position;

  logic [7:0]    win      [PATTERN_MAX];
  logic [7:0]    win_next [PATTERN_MAX];
  logic [CW-1:0] count;
  logic          count_ovf;

  logic [NW-1:0] n;
  logic [LW-1:0] len_ext;
  logic          window_match;
  logic          in_range;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] count_after;
  logic          ovf_after;
  logic [EW-1:0] inc_e;
  logic [EW-1:0] n_e;
  logic [EW-1:0] start_e;
  logic [EW-1:0] begin_e;
  logic [EW-1:0] after_e;
  logic [EW-1:0] empty_pos;
  logic          empty_pat;
  logic          empty_hit;
  logic          saturated;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= LEN_BITS'(1);
      start_position <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_BITS-1:0];
        REG_START_POSITION: start_position <= cfg_data[POS_OUT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign len_ext = LW'(pattern_length);
  assign n = (len_ext > LW'(PATTERN_MAX)) ? NW'(PATTERN_MAX) : NW'(len_ext);

  always_comb begin
    win_next[PATTERN_MAX-1] = in_item.text_byte;
    for (int i = 0; i < PATTERN_MAX - 1; i++) begin
      win_next[i] = win[i+1];
    end
  end

  // Age a counts back from the newest byte; it pairs with pattern byte n-1-a.
  always_comb begin
    logic [NW-1:0] idx;
    window_match = 1'b1;
    idx = '0;
    for (int a = 0; a < PATTERN_MAX; a++) begin
      idx = n - NW'(a) - NW'(1);
      if (NW'(a) < n) begin
        if (win_next[PATTERN_MAX-1-a] !=
            pattern_byte(pattern_low, pattern_high, PAT_INDEX_BITS'(idx))) begin
          window_match = 1'b0;
        end
      end
    end
  end

  assign in_range    = !count[CW-1];
  assign count_inc   = count + CW'(1);
  assign count_after = in_range ? count_inc : count;
  assign ovf_after   = count_ovf || !in_range;

  assign inc_e     = EW'(count_inc);
  assign n_e       = EW'(n);
  assign start_e   = EW'(start_position);
  assign begin_e   = inc_e - n_e;
  assign after_e   = EW'(count_after);
  assign saturated = count_after[CW-1];
  assign empty_pat = (n == '0);
  assign empty_hit = (start_e <= after_e);
  assign empty_pos = saturated ? EW'(MAX_POS) : after_e;

  always_comb begin
    rec.hit           = in_range && !empty_pat && (inc_e >= n_e) &&
                        (begin_e >= start_e) && window_match;
    rec.last          = in_item.last_byte;
    rec.empty_pattern = empty_pat;
    rec.empty_hit     = empty_hit;
    rec.overflow      = ovf_after || (empty_pat && empty_hit && saturated);
    rec.position      = empty_pat ? empty_pos[POS_OUT_BITS-1:0]
                                  : begin_e[POS_OUT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        win[i] <= win_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      count_ovf <= 1'b0;
    end else if (accept) begin
      if (in_item.last_byte) begin
        count     <= '0;
        count_ovf <= 1'b0;
      end else begin
        count     <= count_after;
        count_ovf <= ovf_after;
      end
    end
  end

endmodule

/* rtl/ss_back.sv */
module ss_back import ss_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      rec_valid,
  input  step_rec_t rec,
  input  logic      res_full,
  output logic      rec_take,
  output logic      res_push,
  output result_t   res
);

  logic                    seen;
  logic [POS_OUT_BITS-1:0] first;
  logic                    seen_eff;
  logic [POS_OUT_BITS-1:0] first_eff;

  assign rec_take  = rec_valid && (!rec.last || !res_full);
  assign res_push  = rec_take && rec.last;
  assign seen_eff  = seen || rec.hit;
  assign first_eff = seen ? first : rec.position;

  always_comb begin
    res.overflow = rec.overflow;
    if (rec.empty_pattern) begin
      res.found          = rec.empty_hit;
      res.match_position = rec.empty_hit ? rec.position : '0;
    end else begin
      res.found          = seen_eff;
      res.match_position = seen_eff ? first_eff : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (rec_take) begin
      if (rec.last) begin
        seen <= 1'b0;
      end else if (rec.hit) begin
        seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_take && !rec.last && rec.hit && !seen) begin
      first <= rec.position;
    end
  end

endmodule

/* rtl/substring_search.sv */
// Channel  | Signals                        | Moves
// ---------+--------------------------------+--------------------------------------
// text in  | push, full, in_item            | one text byte per request
// result   | empty, pop, result             | one result per text, at its last byte
// config   | cfg_we, cfg_index, cfg_data    | register write, no wait, no read-back
//
// One text byte is taken every cycle while full is low; the window compare and
// position counter in the front handle a byte per cycle, and a two-entry queue
// feeds the back; the back pushes a result as it takes a text's last record.
// Synchronous reset clears the counters, queues and registers; no clearing pass.
// A stalled result side fills the queues and then raises full.
module substring_search import ss_pkg::*; #(
  parameter int PATTERN_MAX   = PATTERN_MAX_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      push,
  output logic                      full,
  input  text_item_t                in_item,
  output logic                      empty,
  input  logic                      pop,
  output result_t                   result
);

  logic      accept;
  step_rec_t front_rec;
  step_rec_t mid_rec;
  logic      mid_full;
  logic      mid_empty;
  logic      rec_take;
  logic      res_push;
  logic      res_full;
  result_t   back_res;

  assign full   = mid_full;
  assign accept = push && !mid_full;

  ss_front #(
    .PATTERN_MAX   (PATTERN_MAX),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_item   (in_item),
    .rec       (front_rec)
  );

  ss_fifo #(
    .WIDTH ($bits(step_rec_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (front_rec),
    .rd_en   (rec_take),
    .rd_data (mid_rec),
    .full    (mid_full),
    .empty   (mid_empty)
  );

  ss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (!mid_empty),
    .rec       (mid_rec),
    .res_full  (res_full),
    .rec_take  (rec_take),
    .res_push  (res_push),
    .res       (back_res)
  );

  ss_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (back_res),
    .rd_en   (pop),
    .rd_data (result),
    .full    (res_full),
    .empty   (empty)
  );

endmodule

/* tb/tb_top.sv */
module tb_top;
  import ss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_POS = (1 << POSITION_BITS_DEF) - 1;
  localparam result_t NO_RESULT = '0;

  typedef enum logic [1:0] {
    ROW_REG,
    ROW_FILL,
    ROW_TEXT
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_reg_t    sel;
    logic [31:0] count;
    logic [63:0] data;
    logic        last;
    logic        typed;
    result_t     want;
  } stim_row_t;

  typedef struct {
    bit      typed;
    result_t want;
  } byte_tag_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      push;
  logic                      full;
  text_item_t                in_item;
  logic                      empty;
  logic                      pop;
  result_t                   result;

  substring_search u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  logic [63:0] pat_lo    = '0;
  logic [63:0] pat_hi    = '0;
  logic [4:0]  pat_len   = 5'd1;
  logic [15:0] start_pos = '0;

  logic [7:0]  win [16];
  int unsigned win_count = 0;
  bit          seen_hit  = 1'b0;
  logic [15:0] hit_pos   = '0;
  bit          seen_ovf  = 1'b0;

  result_t   pending_results [$];
  byte_tag_t byte_tags [$];
  int        mismatches = 0;

  bit calm    = 1'b0;
  bit steady  = 1'b0;
  bit hold_go = 1'b0;
  int send_gap_pct = 20;
  int pop_gap_pct  = 20;

  stim_row_t directed_rows [34] = '{
    '{ROW_TEXT, REG_PATTERN_LOW, 32'd1, 64'h00, 1'b1, 1'b1, '{1'b1, 16'd0, 1'b0}},
    '{ROW_TEXT, REG_PATTERN_LOW, 32'd1, 64'hFF, 1'b1, 1'b1, '{1'b0, 16'd0, 1'b0}},
    '{ROW_REG, REG_PATTERN_LOW, 32'd0, 64'h0000_0000_0003_0201, 1'b0, 1'b0, NO_RESULT},
    '{ROW_REG, REG_PATTERN_LENGTH, 32'd0, 64'd3, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT, REG_PATTERN_LOW, 32'd4, 64'h0302_0109, 1'b1, 1'b1, '{1'b1, 16'd1, 1'b0}},
    '{ROW_REG, REG_PATTERN_LOW, 32'd0, 64'h0000_0000_0062_6161, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT, REG_PATTERN_LOW, 32'd4, 64'h6261_6161, 1'b1, 1'b1, '{1'b1, 16'd1, 1'b0}},
    '{ROW_REG, REG_PATTERN_LOW, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_REG, REG_PATTERN_HIGH, 32'd0, 64'h0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_REG, REG_PATTERN_LENGTH, 32'd0, 64'd31, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT, REG_PATTERN_LOW, 32'd8, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT, REG_PATTERN_LOW, 32'd8, 64'h0, 1'b1, 1'b1, '{1'b1, 16'd0, 1'b0}},
    '{ROW_REG, REG_PATTERN_LENGTH, 32'd0, 64'd0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT, REG_PATTERN_LOW, 32'd3, 64'h00FF_80, 1'b1, 1'b1, '{1'b1, 16'd3, 1'b0}},
    '{ROW_REG, REG_START_POSITION, 32'd0, 64'd5, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT, REG_PATTERN_LOW, 32'd3, 64'h1234_56, 1'b1, 1'b1, '{1'b0, 16'd0, 1'b0}},
    '{ROW_REG, REG_START_POSITION, 32'd0, 64'd3, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT, REG_PATTERN_LOW, 32'd3, 64'h7F01_FE, 1'b1, 1'b1, '{1'b1, 16'd3, 1'b0}},
    '{ROW_REG, REG_PATTERN_LOW, 32'd0, 64'h41, 1'b0, 1'b0, NO_RESULT},
    '{ROW_REG, REG_PATTERN_LENGTH, 32'd0, 64'd1, 1'b0, 1'b0, NO_RESULT},
    '{ROW_REG, REG_START_POSITION, 32'd0, 64'd2, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT, REG_PATTERN_LOW, 32'd4, 64'h4141_4141, 1'b1, 1'b1, '{1'b1, 16'd2, 1'b0}},
    '{ROW_TEXT, REG_PATTERN_LOW, 32'd2, 64'h4241, 1'b0, 1'b0, NO_RESULT},
    '{ROW_REG, REG_PATTERN_LOW, 32'd0, 64'h42, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT, REG_PATTERN_LOW, 32'd2, 64'h4142, 1'b1, 1'b0, NO_RESULT},
    '{ROW_REG, REG_START_POSITION, 32'd0, 64'hFFFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT, REG_PATTERN_LOW, 32'd2, 64'h4242, 1'b1, 1'b1, '{1'b0, 16'd0, 1'b0}},
    '{ROW_REG, REG_START_POSITION, 32'd0, 64'd0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_REG, REG_PATTERN_LOW, 32'd0, 64'h5A, 1'b0, 1'b0, NO_RESULT},
    '{ROW_FILL, REG_PATTERN_LOW, 32'd65535, 64'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT, REG_PATTERN_LOW, 32'd2, 64'h5A5A, 1'b1, 1'b1, '{1'b1, 16'hFFFF, 1'b1}},
    '{ROW_REG, REG_PATTERN_LENGTH, 32'd0, 64'd0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_FILL, REG_PATTERN_LOW, 32'd65535, 64'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT, REG_PATTERN_LOW, 32'd1, 64'h00, 1'b1, 1'b1, '{1'b1, 16'hFFFF, 1'b1}}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    foreach (win[i]) win[i] = '0;
  end

  function automatic void apply_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                    input logic [63:0] data);
    case (cfg_reg_t'(idx))
      REG_PATTERN_LOW: pat_lo = data;
      REG_PATTERN_HIGH: pat_hi = data;
      REG_PATTERN_LENGTH: pat_len = data[4:0];
      REG_START_POSITION: start_pos = data[15:0];
      default: ;
    endcase
  endfunction

  function automatic bit search_step(input logic [7:0] b, input logic lastb,
                                     output result_t r);
    int unsigned eff;
    int unsigned pos;
    int unsigned first;
    bit          hit;
    logic [127:0] pat_all;
    r = '0;
    pat_all = {pat_hi, pat_lo};
    eff = (pat_len > 5'd16) ? 16 : int'(pat_len);
    pos = win_count;
    for (int k = 0; k < 15; k++) win[k] = win[k+1];
    win[15] = b;
    if (pos > MAX_POS) begin
      seen_ovf = 1'b1;
    end else begin
      win_count = pos + 1;
      if (eff > 0 && !seen_hit && pos + 1 >= eff) begin
        first = pos + 1 - eff;
        if (first >= start_pos) begin
          hit = 1'b1;
          for (int k = 0; k < eff; k++) begin
            if (win[16-eff+k] != pat_all[8*k +: 8]) hit = 1'b0;
          end
          if (hit) begin
            seen_hit = 1'b1;
            hit_pos = first[15:0];
          end
        end
      end
    end
    if (!lastb) return 1'b0;
    r.overflow = seen_ovf;
    if (eff == 0) begin
      if (start_pos <= win_count) begin
        r.found = 1'b1;
        if (win_count > MAX_POS) begin
          r.match_position = MAX_POS[15:0];
          r.overflow = 1'b1;
        end else begin
          r.match_position = win_count[15:0];
        end
      end
    end else if (seen_hit) begin
      r.found = 1'b1;
      r.match_position = hit_pos;
    end
    foreach (win[i]) win[i] = '0;
    win_count = 0;
    seen_hit = 1'b0;
    hit_pos = '0;
    seen_ovf = 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    byte_tag_t tag;
    result_t   r;
    result_t   want;
    if (!rst) begin
      if (cfg_we) apply_reg(cfg_index, cfg_data);
      if (push && !full) begin
        tag = byte_tags.pop_front();
        if (search_step(in_item.text_byte, in_item.last_byte, r)) begin
          pending_results.push_back(tag.typed ? tag.want : r);
        end
      end
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result expected none actual %h", $time, result);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (result.found !== want.found) begin
            $display("%0t: found expected %0b actual %0b", $time, want.found, result.found);
            mismatches++;
          end
          if (result.match_position !== want.match_position) begin
            $display("%0t: match_position expected %0d actual %0d", $time,
                     want.match_position, result.match_position);
            mismatches++;
          end
          if (result.overflow !== want.overflow) begin
            $display("%0t: overflow expected %0b actual %0b", $time,
                     want.overflow, result.overflow);
            mismatches++;
          end
        end
      end
    end
  end

  // The result side pops at random, and once holds off for a long stretch on request.
  initial begin
    pop <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_go) begin
        hold_go = 1'b0;
        pop <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!calm && $urandom_range(1, 100) <= pop_gap_pct) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lastb, input bit typed,
                           input result_t want);
    cfg_we <= 1'b0;
    if (!calm && !steady && $urandom_range(1, 100) <= send_gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    push <= 1'b1;
    in_item <= {b, lastb};
    byte_tags.push_back('{typed, want});
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic wait_quiet();
    push <= 1'b0;
    cfg_we <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || byte_tags.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= data;
    @(posedge clk);
  endtask

  initial begin
    stim_row_t  row;
    bit         fin;
    bit         plant;
    bit         open_end;
    int         sent;
    int         n;
    int         off;
    int         eff;
    logic [7:0] a0;
    logic [7:0] a1;
    logic [7:0] pb [16];
    logic [7:0] txt [$];
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  plen;
    logic [15:0] spos;

    rst <= 1'b1;
    push <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_PATTERN_LOW;
    cfg_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_REG: begin
          wait_quiet();
          write_reg(row.sel, row.data);
        end
        ROW_FILL: begin
          steady = 1'b1;
          repeat (row.count) send_byte(row.data[7:0], 1'b0, 1'b0, NO_RESULT);
          steady = 1'b0;
        end
        default: begin
          for (int j = 0; j < row.count; j++) begin
            fin = row.last && (j == row.count - 1);
            send_byte(row.data[8*j +: 8], fin, fin && row.typed, row.want);
          end
        end
      endcase
    end

    for (int ph = 0; ph < 14; ph++) begin
      a0 = 8'($urandom_range(0, 255));
      a1 = 8'($urandom_range(0, 255));
      foreach (pb[k]) pb[k] = $urandom_range(0, 1) ? a0 : a1;
      if (ph == 7) foreach (pb[k]) pb[k] = 8'hFF;
      if (ph == 8) foreach (pb[k]) pb[k] = 8'h00;
      case (ph)
        0, 9: plen = 5'd16;
        1: plen = 5'd0;
        2: plen = 5'($urandom_range(17, 31));
        11: plen = 5'($urandom_range(5, 16));
        default: plen = 5'($urandom_range(1, 4));
      endcase
      eff = (plen > 5'd16) ? 16 : int'(plen);
      if (ph == 3) spos = 16'hFFFF;
      else if (ph == 10) spos = 16'($urandom_range(0, 65535));
      else if (ph % 3 == 1) spos = 16'($urandom_range(1, 8));
      else spos = '0;
      for (int k = 0; k < 8; k++) begin
        lo[8*k +: 8] = (k < eff) ? pb[k] : 8'($urandom);
        hi[8*k +: 8] = (k + 8 < eff) ? pb[k+8] : 8'($urandom);
      end

      wait_quiet();
      write_reg(REG_PATTERN_LOW, lo);
      write_reg(REG_PATTERN_HIGH, hi);
      write_reg(REG_PATTERN_LENGTH, {$urandom, 27'($urandom), plen});
      write_reg(REG_START_POSITION, {$urandom, 16'($urandom), spos});

      calm = (ph >= 12);
      case ($urandom_range(0, 2))
        0: send_gap_pct = 0;
        1: send_gap_pct = 10;
        default: send_gap_pct = 35;
      endcase
      case ($urandom_range(0, 2))
        0: pop_gap_pct = 0;
        1: pop_gap_pct = 10;
        default: pop_gap_pct = 35;
      endcase
      if (ph == 5) hold_go = 1'b1;

      sent = 0;
      while (sent < 36) begin
        n = (ph == 5) ? 1 : $urandom_range(1, 12);
        plant = (ph != 5) && (eff > 0) && ($urandom_range(0, 1) == 1);
        if (plant) n = eff + $urandom_range(0, 8);
        txt.delete();
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 7) == 0) txt.push_back(8'($urandom));
          else txt.push_back($urandom_range(0, 1) ? a0 : a1);
        end
        if (plant) begin
          off = $urandom_range(0, n - eff);
          for (int k = 0; k < eff; k++) txt[off+k] = pb[k];
        end
        open_end = (ph % 4 == 2) && (sent + n >= 36);
        for (int i = 0; i < n; i++) begin
          fin = (i == n - 1) && !open_end;
          send_byte(txt[i], fin, 1'b0, NO_RESULT);
        end
        sent += n;
      end
    end

    wait_quiet();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
